// ===== sv/sle_pkg.sv =====
// Shared types, constants and helpers for the sequential list engine.
// No dependencies; every module of the block imports this package.
package sle_pkg;

  localparam int LIST_DEPTH = 64;
  localparam int ELEM_W     = 32;
  localparam int ADDR_W     = $clog2(LIST_DEPTH);
  localparam int CNT_W      = 7;
  localparam int VALUE_W    = 32;

  typedef logic [ELEM_W-1:0] elem_t;
  typedef logic [CNT_W-1:0]  cnt_t;

  typedef enum logic [2:0] {
    CMD_CLEAR  = 3'd0,
    CMD_GET    = 3'd1,
    CMD_LOCATE = 3'd2,
    CMD_INSERT = 3'd3,
    CMD_DELETE = 3'd4,
    CMD_SORT   = 3'd5
  } cmd_t;

  typedef enum logic [1:0] {
    ST_DONE     = 2'd0,
    ST_BAD      = 2'd1,
    ST_NOTFOUND = 2'd2
  } status_t;

  // Result of the shared comparator.
  typedef struct packed {
    logic gt;
    logic eq;
  } cmp_res_t;

  // Sign-extends the 32-bit input value and keeps the element's low bits.
  function automatic elem_t to_elem(input logic [VALUE_W-1:0] v);
    logic signed [63:0] ext;
    ext = 64'($signed(v));
    return ext[ELEM_W-1:0];
  endfunction

  // Zero-extends or truncates an element to the 32-bit read value.
  function automatic logic [VALUE_W-1:0] to_value(input elem_t e);
    logic [63:0] ext;
    ext = 64'(e);
    return ext[VALUE_W-1:0];
  endfunction

endpackage

// ===== sv/sle_cmp.sv =====
// Shared signed comparator used by locate and sort.
// Depends on sle_pkg.
module sle_cmp (
  input  sle_pkg::elem_t    lhs,
  input  sle_pkg::elem_t    rhs,
  output sle_pkg::cmp_res_t res
);
  import sle_pkg::*;

  always_comb begin
    res.gt = $signed(lhs) > $signed(rhs);
    res.eq = lhs == rhs;
  end

endmodule

// ===== sv/sequential_list_engine_core.sv =====
// Top level of the sequential list engine: command sequencer and element memory.
// Depends on sle_pkg and sle_cmp.
//
//  Group   Direction  tdata (low bit up)                     tuser
//  s_*     in         position[6:0], value[38:7]             command[2:0]
//  m_*     out        read_value[31:0], found_position[38:32],
//                     element_total[45:39]                   status[1:0]
//
// Each command word is worked through by a small sequencer around a memory with
// one read and one write port (one read and one write a cycle, registered read
// data) and one shared signed comparator. Locate, insert and delete walk the
// list one element at a time, each element taking a memory read and then a
// compare or a write, and sort is an insertion sort in which every step costs
// one memory read and one compare.
// Reset clears the count and the control state; the memory is left as it is.
// s_tready is high only while no command is in progress; a finished result waits
// in the output register and a new command may be accepted meanwhile.
module sequential_list_engine_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // position[6:0], value[38:7], zero pad
  input  logic [2:0]  s_tuser,   // command[2:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // read_value[31:0], found_position[38:32],
                                 // element_total[45:39], zero pad
  output logic [1:0]  m_tuser    // status[1:0]
);
  import sle_pkg::*;

  typedef enum logic [14:0] {
    S_IDLE     = 15'b000000000000001,
    S_GET_RD   = 15'b000000000000010,
    S_GET_TAKE = 15'b000000000000100,
    S_LOC_RD   = 15'b000000000001000,
    S_LOC_CMP  = 15'b000000000010000,
    S_INS_RD   = 15'b000000000100000,
    S_INS_WR   = 15'b000000001000000,
    S_INS_PUT  = 15'b000000010000000,
    S_DEL_RD   = 15'b000000100000000,
    S_DEL_WR   = 15'b000001000000000,
    S_SRT_FET  = 15'b000010000000000,
    S_SRT_HOLD = 15'b000100000000000,
    S_SRT_RD   = 15'b001000000000000,
    S_SRT_CMP  = 15'b010000000000000,
    S_FIN      = 15'b100000000000000
  } state_t;

  state_t  state, state_next;

  // Element memory: one write and one registered read a cycle.
  elem_t   mem [LIST_DEPTH];
  elem_t   rdata;
  logic    we;
  logic [ADDR_W-1:0] waddr, raddr;
  elem_t   wdata;

  // Working registers. word holds the command's value, and the element being
  // placed during a sort.
  cnt_t    count;
  cnt_t    pos;
  elem_t   word;
  cnt_t    idx;      // scan index for locate, insert, delete
  cnt_t    outer;    // sort: element being placed
  cnt_t    inner;    // sort: hole position
  status_t res_status;
  logic [VALUE_W-1:0] res_read;
  cnt_t    res_found;

  cmp_res_t cmp;

  logic    in_fire;
  logic    out_free;
  cnt_t    in_pos;
  cmd_t    in_cmd;
  status_t in_status;
  cnt_t    outer_inc;
  cnt_t    pos_dec;
  cnt_t    idx_dec;
  cnt_t    idx_inc;
  cnt_t    inner_dec;

  assign in_fire   = s_tvalid && s_tready;
  assign s_tready  = state == S_IDLE;
  assign out_free  = !m_tvalid || m_tready;
  assign in_pos    = s_tdata[6:0];
  assign in_cmd    = cmd_t'(s_tuser);
  assign outer_inc = outer + cnt_t'(1);
  assign pos_dec   = pos - cnt_t'(1);
  assign idx_dec   = idx - cnt_t'(1);
  assign idx_inc   = idx + cnt_t'(1);
  assign inner_dec = inner - cnt_t'(1);

  sle_cmp u_cmp (
    .lhs (rdata),
    .rhs (word),
    .res (cmp)
  );

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  // Memory port control follows the state.
  always_comb begin
    we    = 1'b0;
    waddr = idx[ADDR_W-1:0];
    wdata = rdata;
    raddr = idx[ADDR_W-1:0];
    case (state)
      S_GET_RD:  raddr = pos_dec[ADDR_W-1:0];
      S_INS_RD:  raddr = idx_dec[ADDR_W-1:0];
      S_INS_WR:  we = 1'b1;
      S_INS_PUT: begin
        we    = 1'b1;
        waddr = pos_dec[ADDR_W-1:0];
        wdata = word;
      end
      S_DEL_RD:  raddr = idx_inc[ADDR_W-1:0];
      S_DEL_WR:  we = 1'b1;
      S_SRT_FET: raddr = outer[ADDR_W-1:0];
      S_SRT_RD: begin
        raddr = inner_dec[ADDR_W-1:0];
        if (inner == '0) begin
          we    = 1'b1;
          waddr = '0;
          wdata = word;
        end
      end
      S_SRT_CMP: begin
        we    = 1'b1;
        waddr = inner[ADDR_W-1:0];
        wdata = cmp.gt ? rdata : word;
      end
      default: ;
    endcase
  end

  // Status of a command word, decided as it is accepted; a locate starts out
  // as a miss and is put right when the value turns up.
  always_comb begin
    in_status = ST_DONE;
    case (in_cmd)
      CMD_CLEAR, CMD_SORT: in_status = ST_DONE;
      CMD_GET: begin
        if (in_pos == '0 || in_pos > count) in_status = ST_BAD;
      end
      CMD_LOCATE: in_status = ST_NOTFOUND;
      CMD_INSERT: begin
        if (in_pos == '0 || in_pos > count + cnt_t'(1) ||
            count >= cnt_t'(LIST_DEPTH)) begin
          in_status = ST_BAD;
        end
      end
      CMD_DELETE: begin
        if (in_pos == '0 || in_pos > count) in_status = ST_BAD;
      end
      default: in_status = ST_BAD;
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_fire) begin
          case (in_cmd)
            CMD_CLEAR: state_next = S_FIN;
            CMD_GET: begin
              if (in_pos == '0 || in_pos > count) state_next = S_FIN;
              else                                state_next = S_GET_RD;
            end
            CMD_LOCATE: state_next = (count == '0) ? S_FIN : S_LOC_RD;
            CMD_INSERT: begin
              if (in_pos == '0 || in_pos > count + cnt_t'(1) ||
                  count >= cnt_t'(LIST_DEPTH)) begin
                state_next = S_FIN;
              end else if (in_pos == count + cnt_t'(1)) begin
                state_next = S_INS_PUT;
              end else begin
                state_next = S_INS_RD;
              end
            end
            CMD_DELETE: begin
              if (in_pos == '0 || in_pos >= count) state_next = S_FIN;
              else                                 state_next = S_DEL_RD;
            end
            CMD_SORT: state_next = (count < cnt_t'(2)) ? S_FIN : S_SRT_FET;
            default:  state_next = S_FIN;
          endcase
        end
      end
      S_GET_RD:   state_next = S_GET_TAKE;
      S_GET_TAKE: state_next = S_FIN;
      S_LOC_RD:   state_next = S_LOC_CMP;
      S_LOC_CMP: begin
        if (cmp.eq || idx + cnt_t'(1) == count) state_next = S_FIN;
        else                                    state_next = S_LOC_RD;
      end
      S_INS_RD:   state_next = S_INS_WR;
      S_INS_WR:   state_next = (idx == pos) ? S_INS_PUT : S_INS_RD;
      S_INS_PUT:  state_next = S_FIN;
      S_DEL_RD:   state_next = S_DEL_WR;
      S_DEL_WR:   state_next = (idx + cnt_t'(2) < count) ? S_DEL_RD : S_FIN;
      S_SRT_FET:  state_next = S_SRT_HOLD;
      S_SRT_HOLD: state_next = S_SRT_RD;
      S_SRT_RD: begin
        if (inner != '0)            state_next = S_SRT_CMP;
        else if (outer_inc < count) state_next = S_SRT_FET;
        else                        state_next = S_FIN;
      end
      S_SRT_CMP: begin
        if (cmp.gt)                 state_next = S_SRT_RD;
        else if (outer_inc < count) state_next = S_SRT_FET;
        else                        state_next = S_FIN;
      end
      S_FIN:      state_next = out_free ? S_IDLE : S_FIN;
      default:    state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      // A new result is loaded as the old one leaves, or into an empty register.
      if (state == S_FIN && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_fire) begin
            pos        <= in_pos;
            word       <= to_elem(s_tdata[38:7]);
            res_status <= in_status;
            res_read   <= '0;
            res_found  <= '0;
            outer      <= cnt_t'(1);
            case (in_cmd)
              CMD_CLEAR:  count <= '0;
              CMD_LOCATE: idx <= '0;
              CMD_INSERT: idx <= count;
              CMD_DELETE: begin
                idx <= in_pos - cnt_t'(1);
                if (in_pos != '0 && in_pos == count) begin
                  // Last element: nothing moves.
                  count <= count - cnt_t'(1);
                end
              end
              default: ;
            endcase
          end
        end
        S_GET_TAKE: res_read <= to_value(rdata);
        S_LOC_CMP: begin
          if (cmp.eq) begin
            res_found  <= idx + cnt_t'(1);
            res_status <= ST_DONE;
          end
          idx <= idx + cnt_t'(1);
        end
        S_INS_WR:  idx <= idx - cnt_t'(1);
        S_INS_PUT: count <= count + cnt_t'(1);
        S_DEL_WR: begin
          idx <= idx + cnt_t'(1);
          if (!(idx + cnt_t'(2) < count)) begin
            count <= count - cnt_t'(1);
          end
        end
        S_SRT_HOLD: begin
          word  <= rdata;
          inner <= outer;
        end
        S_SRT_RD: begin
          if (inner == '0) begin
            outer <= outer_inc;
          end
        end
        S_SRT_CMP: begin
          if (cmp.gt) inner <= inner - cnt_t'(1);
          else        outer <= outer_inc;
        end
        S_FIN: begin
          if (out_free) begin
            m_tuser  <= res_status;
            m_tdata  <= {2'b00, count, res_found, res_read};
          end
        end
        default: ;
      endcase
    end
  end

endmodule

// ===== bench/list_engine_checker.sv =====
`timescale 1ns / 100ps
// Scoreboard for the sequential list engine. It watches both streams, keeps its
// own copy of the list and checks each result word. Depends on sle_pkg.
module list_engine_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [39:0] s_tdata,   // position[6:0], value[38:7], zero pad
  input  logic [2:0]  s_tuser,   // command[2:0]
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [47:0] m_tdata,   // read_value[31:0], found_position[38:32],
                                 // element_total[45:39], zero pad
  input  logic [1:0]  m_tuser,   // status[1:0]
  output int          fail_count,
  output int          pending_results
);
  import sle_pkg::*;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] read_value;
    logic [6:0]  found_position;
    logic [6:0]  element_total;
  } list_result_t;

  elem_t        shadow_list [LIST_DEPTH];
  int           shadow_len;
  list_result_t awaited_results [$];
  list_result_t predicted;
  list_result_t observed;

  // Applies one command word to the shadow list and works out its result.
  task automatic run_list_command(input logic [2:0] cmd, input logic [6:0] pos,
                                  input logic [31:0] val, output list_result_t res);
    logic signed [63:0] wide;
    logic [63:0]        widened;
    elem_t              word;
    elem_t              held;
    int                 p;
    int                 a;
    int                 b;
    wide = 64'($signed(val));
    word = wide[ELEM_W-1:0];
    p    = int'(pos);
    res  = '0;
    case (cmd)
      CMD_CLEAR: shadow_len = 0;
      CMD_GET: begin
        if (p < 1 || p > shadow_len) begin
          res.status = ST_BAD;
        end else begin
          widened = '0;
          widened[ELEM_W-1:0] = shadow_list[p-1];
          res.read_value = widened[31:0];
        end
      end
      CMD_LOCATE: begin
        res.status = ST_NOTFOUND;
        for (a = 0; a < shadow_len; a++) begin
          if (res.status == ST_NOTFOUND && shadow_list[a] == word) begin
            res.status = ST_DONE;
            res.found_position = 7'(a + 1);
          end
        end
      end
      CMD_INSERT: begin
        if (p < 1 || p > shadow_len + 1 || shadow_len >= LIST_DEPTH) begin
          res.status = ST_BAD;
        end else begin
          for (a = shadow_len; a >= p; a--) shadow_list[a] = shadow_list[a-1];
          shadow_list[p-1] = word;
          shadow_len++;
        end
      end
      CMD_DELETE: begin
        if (p < 1 || p > shadow_len) begin
          res.status = ST_BAD;
        end else begin
          for (a = p - 1; a + 1 < shadow_len; a++) shadow_list[a] = shadow_list[a+1];
          shadow_len--;
        end
      end
      CMD_SORT: begin
        // Insertion sort, ascending as signed numbers.
        for (a = 1; a < shadow_len; a++) begin
          held = shadow_list[a];
          b = a;
          while (b > 0 && $signed(shadow_list[b-1]) > $signed(held)) begin
            shadow_list[b] = shadow_list[b-1];
            b--;
          end
          shadow_list[b] = held;
        end
      end
      default: res.status = ST_BAD;
    endcase
    res.element_total = 7'(shadow_len);
  endtask

  task automatic check_field(input string label, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      fail_count++;
      $display("%0t ns: %s expected %0h, got %0h", $time, label, want, got);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      shadow_len = 0;
      fail_count = 0;
      awaited_results.delete();
    end else begin
      if (s_tvalid && s_tready) begin
        run_list_command(s_tuser, s_tdata[6:0], s_tdata[38:7], predicted);
        awaited_results.push_back(predicted);
      end
      if (m_tvalid && m_tready) begin
        observed = {m_tuser, m_tdata[31:0], m_tdata[38:32], m_tdata[45:39]};
        if (awaited_results.size() == 0) begin
          fail_count++;
          $display("%0t ns: result word with none awaited, expected nothing, got %0h",
                   $time, observed);
        end else begin
          predicted = awaited_results.pop_front();
          check_field("status", 32'(predicted.status), 32'(observed.status));
          check_field("read_value", predicted.read_value, observed.read_value);
          check_field("found_position", 32'(predicted.found_position),
                      32'(observed.found_position));
          check_field("element_total", 32'(predicted.element_total),
                      32'(observed.element_total));
        end
      end
    end
    pending_results = awaited_results.size();
  end

endmodule

// ===== bench/sequential_list_engine_core_tb.sv =====
`timescale 1ns / 100ps
// Top of the bench for sequential_list_engine_core: clock, reset, command words,
// output back-pressure and the verdict. Depends on sle_pkg, the block and
// list_engine_checker.
module sequential_list_engine_core_tb;
  import sle_pkg::*;

  localparam int         RANDOM_WORDS = 1500;
  localparam int         CYCLE_LIMIT  = 20_000_000;
  localparam int         HOLD_OFF     = 3000;
  localparam int         DRAIN_CYCLES = 100;
  // The two command codes that the block does not define.
  localparam logic [2:0] CMD_SPARE_LO = 3'd6;
  localparam logic [2:0] CMD_SPARE_HI = 3'd7;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [39:0] s_tdata;   // position[6:0], value[38:7], zero pad
  logic [2:0]  s_tuser;   // command[2:0]
  logic        m_tvalid;
  logic        m_tready;
  logic [47:0] m_tdata;   // read_value[31:0], found_position[38:32],
                          // element_total[45:39], zero pad
  logic [1:0]  m_tuser;   // status[1:0]

  int fail_count;
  int pending_results;
  int words_sent;
  // A rough count of the list contents, kept only to aim positions well.
  int list_level;
  int burst_left;
  int fill_goal;
  int goal_left;

  sequential_list_engine_core dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  list_engine_checker u_checker (
    .clk             (clk),
    .rst             (rst),
    .s_tvalid        (s_tvalid),
    .s_tready        (s_tready),
    .s_tdata         (s_tdata),
    .s_tuser         (s_tuser),
    .m_tvalid        (m_tvalid),
    .m_tready        (m_tready),
    .m_tdata         (m_tdata),
    .m_tuser         (m_tuser),
    .fail_count      (fail_count),
    .pending_results (pending_results)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Offers one command word and returns at the falling edge after it has been
  // taken. Words come in bursts of random length; between bursts the valid line
  // drops for a random number of cycles, and sometimes not at all.
  task automatic send_word(input logic [2:0] cmd, input logic [6:0] pos,
                           input logic [31:0] val);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        s_tvalid = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    s_tvalid = 1'b1;
    s_tuser  = cmd;
    s_tdata  = {1'b0, val, pos};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    words_sent++;
    case (cmd)
      CMD_CLEAR: list_level = 0;
      CMD_INSERT: begin
        if (pos >= 1 && pos <= list_level + 1 && list_level < LIST_DEPTH) list_level++;
      end
      CMD_DELETE: begin
        if (pos >= 1 && pos <= list_level) list_level--;
      end
      default: ;
    endcase
    @(negedge clk);
  endtask

  // Values often come from a narrow band around zero, so that locates hit and
  // duplicates occur, with the signed extremes and fully random words mixed in.
  function automatic logic [31:0] pick_value(input int band_pct);
    int r;
    int near_zero;
    r = $urandom_range(0, 99);
    if (r < band_pct) begin
      near_zero = $urandom_range(0, 12);
      return near_zero - 6;
    end
    if (r < band_pct + 15) begin
      case ($urandom_range(0, 3))
        0:       return 32'h8000_0000;
        1:       return 32'h7FFF_FFFF;
        2:       return '0;
        default: return '1;
      endcase
    end
    return $urandom();
  endfunction

  // Mostly a legal position up to the given bound; otherwise zero, one past the
  // bound, or anything the field can hold.
  function automatic logic [6:0] pick_position(input int upper);
    if (upper >= 1 && $urandom_range(0, 99) < 85) return 7'($urandom_range(1, upper));
    case ($urandom_range(0, 2))
      0:       return '0;
      1:       return (upper + 1 > 127) ? 7'd127 : 7'(upper + 1);
      default: return 7'($urandom_range(0, 127));
    endcase
  endfunction

  // Builds one random command word. The list is steered towards a goal level
  // that changes from time to time, so that it is often full, often nearly
  // empty and often in between.
  task automatic random_word();
    int         r;
    int         ins_share;
    logic [2:0] cmd;
    logic [6:0] pos;
    logic [31:0] val;
    if (goal_left == 0) begin
      goal_left = $urandom_range(30, 120);
      case ($urandom_range(0, 3))
        0:       fill_goal = LIST_DEPTH;
        1:       fill_goal = $urandom_range(0, 4);
        default: fill_goal = $urandom_range(0, LIST_DEPTH);
      endcase
    end
    goal_left--;
    ins_share = (list_level < fill_goal) ? 50 : (list_level > fill_goal) ? 11 : 30;
    r   = $urandom_range(0, 99);
    val = $urandom();
    pos = 7'($urandom_range(0, 127));
    if (r < ins_share) begin
      cmd = CMD_INSERT;
      pos = pick_position(list_level + 1);
      val = pick_value(40);
    end else if (r < 61) begin
      cmd = CMD_DELETE;
      pos = pick_position(list_level);
    end else if (r < 79) begin
      cmd = CMD_GET;
      pos = pick_position(list_level);
    end else if (r < 94) begin
      cmd = CMD_LOCATE;
      val = pick_value(60);
    end else if (r < 97) begin
      cmd = CMD_SORT;
    end else if (r < 98) begin
      cmd = CMD_CLEAR;
    end else begin
      cmd = ($urandom_range(0, 1) == 0) ? CMD_SPARE_LO : CMD_SPARE_HI;
    end
    send_word(cmd, pos, val);
  endtask

  // Receiver: ready follows a pattern that changes mode every so often. Once a
  // few hundred words have gone in, it holds off for a long stretch so that the
  // result register fills, the block stalls and the sender is kept waiting.
  initial begin : receiver
    int mode;
    int mode_left;
    bit held_off;
    mode      = 0;
    mode_left = 0;
    held_off  = 1'b0;
    m_tready  = 1'b0;
    forever begin
      @(negedge clk);
      if (!held_off && words_sent >= 300) begin
        held_off = 1'b1;
        m_tready = 1'b0;
        repeat (HOLD_OFF) @(negedge clk);
      end
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 3);
        mode_left = $urandom_range(20, 200);
      end
      mode_left--;
      case (mode)
        0:       m_tready = 1'b1;
        1:       m_tready = ($urandom_range(0, 3) != 0);
        2:       m_tready = ($urandom_range(0, 3) == 0);
        default: m_tready = ~m_tready;
      endcase
    end
  end

  initial begin : watchdog
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("sequential_list_engine_core: mismatch");
    $finish;
  end

  initial begin : stimulus
    int n;
    rst        = 1'b1;
    s_tvalid   = 1'b0;
    s_tdata    = '0;
    s_tuser    = '0;
    words_sent = 0;
    list_level = 0;
    burst_left = 0;
    // The first random stretch fills the list right up, so that inserts into a
    // full list are certain to be seen.
    fill_goal  = LIST_DEPTH;
    goal_left  = 250;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed part. On the empty list, get and delete are refused, a locate
    // misses and a sort does nothing.
    send_word(CMD_GET,    7'd1, 32'd0);
    send_word(CMD_DELETE, 7'd1, 32'd0);
    send_word(CMD_LOCATE, 7'd0, 32'd0);
    send_word(CMD_SORT,   7'd0, 32'd0);
    // Insert at position zero and past the end are both refused.
    send_word(CMD_INSERT, 7'd0, 32'd5);
    send_word(CMD_INSERT, 7'd2, 32'd5);
    // Build the list from the signed extremes, sorting it while it holds one.
    send_word(CMD_INSERT, 7'd1, 32'h7FFF_FFFF);
    send_word(CMD_SORT,   7'd0, 32'd0);
    send_word(CMD_INSERT, 7'd1, 32'h8000_0000);
    send_word(CMD_INSERT, 7'd3, 32'd0);
    send_word(CMD_INSERT, 7'd2, 32'hFFFF_FFFF);
    send_word(CMD_INSERT, 7'd127, 32'd1);
    // Reads at the far end of the position field and at the last element.
    send_word(CMD_GET,    7'd127, 32'd0);
    send_word(CMD_GET,    7'd4, 32'd0);
    send_word(CMD_LOCATE, 7'd0, 32'h8000_0000);
    send_word(CMD_LOCATE, 7'd0, 32'hFFFF_FFFF);
    send_word(CMD_LOCATE, 7'd0, 32'd12345);
    // Sorting must put the most negative value first.
    send_word(CMD_SORT,   7'd0, 32'd0);
    send_word(CMD_GET,    7'd1, 32'd0);
    send_word(CMD_DELETE, 7'd4, 32'd0);
    send_word(CMD_DELETE, 7'd1, 32'd0);
    send_word(CMD_DELETE, 7'd0, 32'd0);
    // The undefined command codes are refused and leave the list alone.
    send_word(CMD_SPARE_LO, 7'd1, $urandom());
    send_word(CMD_SPARE_HI, 7'd127, 32'hFFFF_FFFF);
    send_word(CMD_CLEAR,  7'd0, 32'd0);

    for (n = 0; n < RANDOM_WORDS; n++) random_word();
    s_tvalid = 1'b0;

    // Every word gives exactly one result, so once nothing is awaited the block
    // is idle; a short drain then catches any stray result word.
    while (pending_results != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0 && pending_results == 0) begin
      $display("sequential_list_engine_core: match");
    end else begin
      $display("sequential_list_engine_core: mismatch");
    end
    $finish;
  end

endmodule
